// File: rtl/clws_pkg.sv
package clws_pkg;

    localparam int VALUE_W        = 32;
    localparam int DEC_DIGITS_32  = 10;
    localparam int MAX_DIGITS_DEF = 10;
    localparam int STEP_W         = $clog2(VALUE_W);

    localparam logic [1:0] MODE_CMD  = 2'd0;
    localparam logic [1:0] MODE_CHAR = 2'd1;
    localparam logic [1:0] MODE_NUM  = 2'd2;
    localparam logic [1:0] MODE_INIT = 2'd3;

    localparam logic [7:0] ASCII_ZERO = 8'd48;

    // Power-up commands: 8-bit bus and two lines, display on, entry mode, clear.
    localparam logic [7:0] INIT_CMDS [4] = '{8'h38, 8'h0C, 8'h06, 8'h01};

    typedef struct packed {
        logic [1:0]         mode;
        logic [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic       reg_select;
        logic [7:0] data_byte;
        logic       last;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_PREP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic prep;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic in_is_num;
        logic conv_done;
        logic last_write;
        logic out_free;
    } t_status;

endpackage

// File: rtl/clws_ctrl.sv
module clws_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  clws_pkg::t_status i_status,
    output clws_pkg::t_cmd   o_cmd,
    output logic             o_in_ready
);

    clws_pkg::t_state r_state;
    clws_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clws_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            clws_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.in_is_num ? clws_pkg::S_CONV : clws_pkg::S_EMIT;
                end
            end
            clws_pkg::S_CONV: begin
                if (i_status.conv_done) begin
                    n_state = clws_pkg::S_PREP;
                end
            end
            clws_pkg::S_PREP: begin
                n_state = clws_pkg::S_EMIT;
            end
            clws_pkg::S_EMIT: begin
                if (i_status.out_free && i_status.last_write) begin
                    n_state = clws_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = clws_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            clws_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            clws_pkg::S_CONV: begin
                o_cmd.conv_step = 1'b1;
            end
            clws_pkg::S_PREP: begin
                o_cmd.prep = 1'b1;
            end
            clws_pkg::S_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/clws_dp.sv
module clws_dp #(
    parameter int MAX_DIGITS = clws_pkg::MAX_DIGITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  clws_pkg::t_in_item  i_in_data,
    input  clws_pkg::t_cmd      i_cmd,
    output clws_pkg::t_status   o_status,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output clws_pkg::t_out_item o_out_data
);

    // Only the digits that can ever be printed are kept.
    localparam int NDIG  = (MAX_DIGITS < clws_pkg::DEC_DIGITS_32) ?
                           MAX_DIGITS : clws_pkg::DEC_DIGITS_32;
    localparam int IDX_W = ($clog2(NDIG) > 2) ? $clog2(NDIG) : 2;

    logic [1:0]                   r_mode;
    logic [7:0]                   r_byte;
    logic [clws_pkg::VALUE_W-1:0] r_bin;
    logic [3:0]                   r_bcd [NDIG];
    logic                         r_ovf;
    logic [clws_pkg::STEP_W-1:0]  r_cnt;
    logic [IDX_W-1:0]             r_idx;
    logic                         r_out_valid;
    clws_pkg::t_out_item          r_out_data;

    logic [3:0]          w_adj [NDIG];
    logic [3:0]          w_dig;
    logic [IDX_W-1:0]    w_msd;
    clws_pkg::t_out_item w_out;

    // Add three to every digit of five or more before the shift.
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            w_adj[d] = (r_bcd[d] >= 4'd5) ? r_bcd[d] + 4'd3 : r_bcd[d];
        end
    end

    always_comb begin
        w_msd = '0;
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[d] != 4'd0) begin
                w_msd = IDX_W'(d);
            end
        end
    end

    always_comb begin
        w_dig = '0;
        for (int d = 0; d < NDIG; d++) begin
            if (r_idx == IDX_W'(d)) begin
                w_dig = r_bcd[d];
            end
        end
    end

    always_comb begin
        w_out      = '0;
        w_out.last = (r_idx == '0);
        case (r_mode)
            clws_pkg::MODE_CMD: begin
                w_out.reg_select = 1'b0;
                w_out.data_byte  = r_byte;
            end
            clws_pkg::MODE_CHAR: begin
                w_out.reg_select = 1'b1;
                w_out.data_byte  = r_byte;
            end
            clws_pkg::MODE_NUM: begin
                w_out.reg_select = 1'b1;
                w_out.data_byte  = clws_pkg::ASCII_ZERO + {4'b0000, w_dig};
            end
            clws_pkg::MODE_INIT: begin
                w_out.reg_select = 1'b0;
                w_out.data_byte  = clws_pkg::INIT_CMDS[~r_idx[1:0]];
            end
            default: begin
                w_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_in_data.mode;
            r_byte <= i_in_data.value[7:0];
            r_bin  <= i_in_data.value;
            r_ovf  <= 1'b0;
            r_cnt  <= clws_pkg::STEP_W'(clws_pkg::VALUE_W - 1);
            r_idx  <= (i_in_data.mode == clws_pkg::MODE_INIT) ? IDX_W'(3) : '0;
            for (int d = 0; d < NDIG; d++) begin
                r_bcd[d] <= 4'd0;
            end
        end else if (i_cmd.conv_step) begin
            r_bin    <= {r_bin[clws_pkg::VALUE_W-2:0], 1'b0};
            r_bcd[0] <= {w_adj[0][2:0], r_bin[clws_pkg::VALUE_W-1]};
            for (int d = 1; d < NDIG; d++) begin
                r_bcd[d] <= {w_adj[d][2:0], w_adj[d-1][3]};
            end
            // A bit leaving the top digit means more digits than are printed.
            r_ovf <= r_ovf | w_adj[NDIG-1][3];
            r_cnt <= r_cnt - 1'b1;
        end else if (i_cmd.prep) begin
            r_idx <= r_ovf ? IDX_W'(NDIG - 1) : w_msd;
        end else if (i_cmd.emit) begin
            r_idx <= r_idx - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= w_out;
        end
    end

    assign o_status.in_is_num  = (i_in_data.mode == clws_pkg::MODE_NUM);
    assign o_status.conv_done  = (r_cnt == '0);
    assign o_status.last_write = (r_idx == '0);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: rtl/char_lcd_write_sequencer_top.sv
// A command or character beat is offered once its request is accepted and the emit state
// loads the output register; an init request gives four beats, one per cycle unstalled.
// A number takes 32 shift steps of a serial binary-to-decimal unit and then a search for the
// leading digit before its first beat, then one digit per cycle while the output is not stalled.
// A new request is taken only after the final beat of the last one is in the output register.
// Reset (synchronous, active low) returns the sequencer to idle and empties the output stage.
module char_lcd_write_sequencer_top #(
    parameter int MAX_DIGITS = clws_pkg::MAX_DIGITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  clws_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output clws_pkg::t_out_item o_out_data
);

    // The controller steps through idle, conversion, leading-digit search and emission.
    // The datapath holds the request, the double-dabble registers, the write index and
    // the output register. Because the output register parts the two sides, the
    // controller returns to idle as soon as the final beat is loaded, and a new request
    // may be taken while that beat still waits for the display side.

    clws_pkg::t_cmd    w_cmd;
    clws_pkg::t_status w_status;

    clws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_ready (o_in_ready)
    );

    // The number of printed digits is capped at MAX_DIGITS; larger numbers show only
    // their least significant digits, leading zeros among them included.
    clws_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// File: rtl/clws_checker.sv
module clws_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input clws_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input clws_pkg::t_out_item o_out_data
);

    // A stalled beat keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // Reset empties the output stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Taking a request drops input ready, so no second request is taken at once.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken at once");

    // While a write that is not the final one waits, the request is still in progress.
    a_busy_mid_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> !o_in_ready)
        else $error("input ready in the middle of a request");

endmodule

bind char_lcd_write_sequencer_top clws_checker u_clws_checker (.*);
